// File: src/icmp_rc_pkg.sv
`default_nettype none

package icmp_rc_pkg;

  // packet size limit and derived counter widths
  localparam int MAX_PACKET_BYTES = 2048;
  localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
  // compare width: wide enough for the count and for offsets up to inner header + 8
  localparam int CMP_W = (CNT_W > 10) ? CNT_W : 10;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [CMP_W-1:0] cmp_t;

  // header layout
  localparam logic [3:0] IPV4_VERSION   = 4'd4;
  localparam int         IPV4_MIN_HDR   = 20;
  localparam int         IPV4_TTL_POS   = 8;
  localparam int         ICMP_HDR_BYTES = 8;
  localparam int         ICMP_SEQ_HI    = 6;
  localparam int         ICMP_SEQ_LO    = 7;

  // icmp types
  localparam logic [7:0] ICMP_TYPE_ECHO_REPLY = 8'd0;
  localparam logic [7:0] ICMP_ECHO_REQUEST    = 8'd8;
  localparam logic [7:0] ICMP_TIME_EXCEEDED   = 8'd11;
  // type seen when byte 0 looks like ipv4 but the packet is too short
  localparam logic [7:0] ICMP_TYPE_SHORT_IP   = 8'h40;

  localparam logic signed [8:0] NO_TTL = -9'sd1;

  // per packet parse state
  typedef struct packed {
    count_t      byte_count;
    logic        has_ip_header;
    logic [5:0]  icmp_start;
    logic [7:0]  outer_ttl;
    logic [7:0]  outer_type;
    logic [15:0] outer_seq;
    logic [7:0]  inner_icmp_start;
    logic [7:0]  inner_type;
    logic [15:0] inner_seq;
  } pkt_state_t;

  localparam pkt_state_t PKT_CLEAR = '0;

  typedef struct packed {
    logic [15:0] expected_sequence;
    logic        datagram_mode;
  } cfg_t;

  // configuration register map
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t REG_EXPECTED_SEQUENCE = 2'd0;
  localparam cfg_index_t REG_DATAGRAM_MODE     = 2'd1;

endpackage

`default_nettype wire

// File: src/icmp_reply_classifier.sv
`default_nettype none
// path: a last byte passes through the input register and then into the verdict register
// throughput: one byte per cycle; a last byte waits only while the verdict register
//   is still full and stalled
// reset: synchronous, clears the parse state, the pipeline valids, and sets
//   expected_sequence to 0 and datagram_mode to 1

module icmp_reply_classifier (
  input  wire logic              clk,
  input  wire logic              rst,
  // byte channel
  input  wire logic              data_valid,
  output logic                   data_stall,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last,
  // verdict channel
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic                   accepted,
  output logic                   echo_reply,
  output logic                   ttl_expired,
  output logic signed [8:0]      reply_ttl,
  // configuration write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire icmp_rc_pkg::cfg_index_t cfg_index,
  input  wire logic [15:0]       cfg_data
);
  import icmp_rc_pkg::*;

  // input register stage
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_go;
  logic       take;

  cfg_t       cfg;
  pkt_state_t upd;

  // a non-last byte always moves on into the parse state; a last byte also
  // needs room in the verdict register (empty, or being taken this cycle)
  assign s1_go      = s1_valid && (!s1_last || !result_valid || !result_stall);
  assign take       = s1_go && s1_last;
  assign data_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data_valid && !data_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // payload of the input stage, no reset needed
  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      s1_byte <= data_byte;
      s1_last <= last;
    end
  end

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_sequence <= 16'd0;
      cfg.datagram_mode     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXPECTED_SEQUENCE: cfg.expected_sequence <= cfg_data;
        REG_DATAGRAM_MODE:     cfg.datagram_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // header field capture, one byte per cycle unless a last byte is stalled
  icmp_rc_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .go        (s1_go),
    .data_byte (s1_byte),
    .last      (s1_last),
    .upd       (upd)
  );

  // verdict from the state including the last byte, into the result register
  icmp_rc_verdict u_verdict (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .st           (upd),
    .cfg          (cfg),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .accepted     (accepted),
    .echo_reply   (echo_reply),
    .ttl_expired  (ttl_expired),
    .reply_ttl    (reply_ttl)
  );

  // a last byte facing a free verdict register produces a word next cycle
  a_last_gives_word: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last && !(result_valid && result_stall) |=> result_valid)
    else $error("last byte did not produce a verdict word");

endmodule

`default_nettype wire

// File: src/icmp_rc_capture.sv
`default_nettype none

module icmp_rc_capture (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    go,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    last,
  output icmp_rc_pkg::pkt_state_t      upd
);
  import icmp_rc_pkg::*;

  pkt_state_t st;
  count_t     idx;
  cmp_t       idx_c;
  cmp_t       start_c;
  cmp_t       inner_ip_c;
  cmp_t       ics_c;
  logic       hi;
  logic [5:0] start;
  logic [7:0] inner_ip;
  logic [7:0] ics;

  // state with the current byte applied
  always_comb begin
    upd        = st;
    idx        = st.byte_count;
    idx_c      = cmp_t'(idx);
    hi         = st.has_ip_header;
    start      = st.icmp_start;
    inner_ip   = 8'({2'b00, start}) + 8'(ICMP_HDR_BYTES);
    ics        = st.inner_icmp_start;
    start_c    = '0;
    inner_ip_c = '0;
    ics_c      = '0;
    if (idx < count_t'(MAX_PACKET_BYTES)) begin
      if (idx == '0) begin
        hi    = (data_byte[7:4] == IPV4_VERSION);
        start = hi ? {data_byte[3:0], 2'b00} : 6'd0;
      end
      upd.has_ip_header = hi;
      upd.icmp_start    = start;
      start_c           = cmp_t'(start);
      if (hi && idx_c == cmp_t'(IPV4_TTL_POS)) begin
        upd.outer_ttl = data_byte;
      end
      if (idx_c == start_c) begin
        upd.outer_type = data_byte;
      end
      if (idx_c == start_c + cmp_t'(ICMP_SEQ_HI)) begin
        upd.outer_seq[15:8] = data_byte;
      end
      if (idx_c == start_c + cmp_t'(ICMP_SEQ_LO)) begin
        upd.outer_seq[7:0] = data_byte;
      end
      // quoted datagram follows the outer icmp header
      inner_ip   = 8'({2'b00, start}) + 8'(ICMP_HDR_BYTES);
      inner_ip_c = cmp_t'(inner_ip);
      if (idx_c >= inner_ip_c) begin
        if (idx_c == inner_ip_c) begin
          ics                  = inner_ip + {2'b00, data_byte[3:0], 2'b00};
          upd.inner_icmp_start = ics;
        end
        ics_c = cmp_t'(ics);
        if (idx_c == ics_c) begin
          upd.inner_type = data_byte;
        end
        if (idx_c == ics_c + cmp_t'(ICMP_SEQ_HI)) begin
          upd.inner_seq[15:8] = data_byte;
        end
        if (idx_c == ics_c + cmp_t'(ICMP_SEQ_LO)) begin
          upd.inner_seq[7:0] = data_byte;
        end
      end
      upd.byte_count = idx + count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PKT_CLEAR;
    end else if (go) begin
      st <= last ? PKT_CLEAR : upd;
    end
  end

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    st.byte_count <= count_t'(MAX_PACKET_BYTES))
    else $error("byte count beyond packet limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    go && last |=> st.byte_count == '0)
    else $error("parse state not cleared after verdict");

endmodule

`default_nettype wire

// File: src/icmp_rc_verdict.sv
`default_nettype none

module icmp_rc_verdict (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    take,
  input  wire icmp_rc_pkg::pkt_state_t st,
  input  wire icmp_rc_pkg::cfg_t       cfg,
  input  wire logic                    result_stall,
  output logic                         result_valid,
  output logic                         accepted,
  output logic                         echo_reply,
  output logic                         ttl_expired,
  output logic signed [8:0]            reply_ttl
);
  import icmp_rc_pkg::*;

  cmp_t              size;
  cmp_t              off;
  logic              ip;
  logic [7:0]        icmp_type;
  logic              hdr_ok;
  logic              trunc;
  logic              inner_ok;
  logic              echo_c;
  logic              ttlx_c;
  logic signed [8:0] rttl_c;

  always_comb begin
    size      = cmp_t'(st.byte_count);
    ip        = st.has_ip_header && (size >= cmp_t'(IPV4_MIN_HDR));
    off       = ip ? cmp_t'(st.icmp_start) : '0;
    rttl_c    = ip ? $signed({1'b0, st.outer_ttl}) : NO_TTL;
    icmp_type = (!ip && st.has_ip_header) ? ICMP_TYPE_SHORT_IP : st.outer_type;
    hdr_ok    = (off + cmp_t'(ICMP_HDR_BYTES)) <= size;
    // quote too short for an ipv4 header plus icmp header
    trunc     = (off + cmp_t'(ICMP_HDR_BYTES + IPV4_MIN_HDR + ICMP_HDR_BYTES)) > size;
    inner_ok  = ((cmp_t'(st.inner_icmp_start) + cmp_t'(ICMP_HDR_BYTES)) <= size)
                && (st.inner_type == ICMP_ECHO_REQUEST)
                && (st.inner_seq == cfg.expected_sequence);
    echo_c    = hdr_ok && (icmp_type == ICMP_TYPE_ECHO_REPLY)
                && (st.outer_seq == cfg.expected_sequence);
    ttlx_c    = hdr_ok && (icmp_type == ICMP_TIME_EXCEEDED)
                && (trunc ? cfg.datagram_mode : inner_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      accepted    <= echo_c || ttlx_c;
      echo_reply  <= echo_c;
      ttl_expired <= ttlx_c;
      reply_ttl   <= rttl_c;
    end
  end

  a_kinds_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(echo_reply && ttl_expired))
    else $error("echo reply and ttl expiry both flagged");

  a_accept_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (accepted == (echo_reply || ttl_expired)))
    else $error("accepted flag disagrees with verdict kind");

endmodule

`default_nettype wire
